@@ rtl/lavm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_pkg: shared types and constants of the look-at view matrix unit
// Holds field widths, the queue entry type, register indexes and defaults.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned DiffW         = DataW + 1;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned QueueDepthDef = 2;

  typedef logic signed [DataW-1:0] lavm_data_t;
  typedef logic signed [DiffW-1:0] lavm_diff_t;

  // one classified camera update waiting for the back end
  typedef struct packed {
    lavm_data_t [2:0] eye;
    lavm_diff_t [2:0] diff;
    logic             same;
  } lavm_entry_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_UP_X = 2'd0,
    CFG_UP_Y = 2'd1,
    CFG_UP_Z = 2'd2
  } lavm_cfg_e;

endpackage
`default_nettype wire

@@ rtl/lavm_item_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_item_if: input channel of the look-at view matrix unit
// Valid/ready channel carrying one eye point and one target point.
// ----------------------------------------------------------------------------
interface lavm_item_if;
  import lavm_pkg::*;

  logic             valid;
  logic             ready;
  logic signed [DataW-1:0] eye_x;
  logic signed [DataW-1:0] eye_y;
  logic signed [DataW-1:0] eye_z;
  logic signed [DataW-1:0] target_x;
  logic signed [DataW-1:0] target_y;
  logic signed [DataW-1:0] target_z;

  modport source (
    output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
    input  ready
  );

  modport sink (
    input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
    output ready
  );

endinterface
`default_nettype wire

@@ rtl/lavm_row_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_row_if: output channel of the look-at view matrix unit
// Valid/ready channel carrying one row of the view matrix.
// ----------------------------------------------------------------------------
interface lavm_row_if;
  import lavm_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       row_index;
  logic signed [DataW-1:0] col0;
  logic signed [DataW-1:0] col1;
  logic signed [DataW-1:0] col2;
  logic signed [DataW-1:0] col3;
  logic             degenerate;
  logic             last_row;

  modport source (
    output valid, row_index, col0, col1, col2, col3, degenerate, last_row,
    input  ready
  );

  modport sink (
    input  valid, row_index, col0, col1, col2, col3, degenerate, last_row,
    output ready
  );

endinterface
`default_nettype wire

@@ rtl/look_at_view_matrix_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit: look-at camera view matrix in signed fixed point
// Builds the camera basis from eye, target and a programmable up vector and
// streams the 4x4 view matrix out one row per transfer.
// ----------------------------------------------------------------------------
// Each transfer on item_i (eye and target, signed Q(31-F).F with F = FRAC_BITS)
// yields four transfers on row_o, rows 0 to 3 in order: side axis, true up
// axis, backward axis (each with the saturated negated dot product with the
// eye in col3) and the constant row 0,0,0,1.0. degenerate is set on all four
// rows when eye equals target or the view direction is parallel to up (or up
// is zero); rows 0 to 2 are then all zero. A normal update runs on the back
// end's single shared 33x33 multiplier, its one-bit-per-cycle square root
// (32 steps) and its one-bit-per-cycle divider (FRAC_BITS+1 steps per
// component, six divisions per update), with a block-float alignment shift
// before each normalization. An update with eye equal to target goes
// straight to the row output. The front end keeps taking updates into a
// QUEUE_DEPTH-entry queue while the back end works, and the row output
// register lets the back end move on while a row waits on ready. The user
// must write configuration (up_x, up_y, up_z at indexes 0, 1, 2) only while
// the unit is idle; the block itself does not enforce this. Writes to any
// other index are ignored.
module look_at_view_matrix_unit #(
  parameter int unsigned FRAC_BITS   = lavm_pkg::FracBitsDef,
  parameter int unsigned QUEUE_DEPTH = lavm_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lavm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lavm_pkg::DataW-1:0]   cfg_wdata_i,
  lavm_item_if.sink                    item_i,
  lavm_row_if.source                   row_o
);
  import lavm_pkg::*;

  // up vector reset value is 1.0 on y
  localparam lavm_data_t UpYReset = DataW'(64'(1) << FRAC_BITS);

  // up vector registers
  lavm_data_t  up_x_q, up_x_d, up_y_q, up_y_d, up_z_q, up_z_d;

  // front to queue, queue to back
  lavm_entry_t push_entry, pop_entry;
  logic        push_valid, push_ready, pop_valid, pop_ready;

  // config write decode, out-of-range index has no effect
  always_comb begin
    up_x_d = up_x_q;
    up_y_d = up_y_q;
    up_z_d = up_z_q;
    if (cfg_we_i) begin
      case (lavm_cfg_e'(cfg_idx_i))
        CFG_UP_X: up_x_d = $signed(cfg_wdata_i);
        CFG_UP_Y: up_y_d = $signed(cfg_wdata_i);
        CFG_UP_Z: up_z_d = $signed(cfg_wdata_i);
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_x_q <= '0;
      up_y_q <= UpYReset;
      up_z_q <= '0;
    end else begin
      up_x_q <= up_x_d;
      up_y_q <= up_y_d;
      up_z_q <= up_z_d;
    end
  end

  // front end: takes transfers, forms eye - target, flags a null direction
  lavm_front u_front (
    .item_i       (item_i),
    .entry_o      (push_entry),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  // decoupling queue
  lavm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_entry),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  // back end: normalize, cross products, dot products, row streaming
  lavm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .up_x_i        (up_x_q),
    .up_y_i        (up_y_q),
    .up_z_i        (up_z_q),
    .entry_i       (pop_entry),
    .entry_valid_i (pop_valid),
    .entry_ready_o (pop_ready),
    .row_o         (row_o)
  );

endmodule
`default_nettype wire

@@ rtl/lavm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_front: input side of the look-at view matrix unit
// Takes camera updates, forms eye minus target and flags eye equal to target.
// ----------------------------------------------------------------------------
module lavm_front (
  lavm_item_if.sink             item_i,
  output lavm_pkg::lavm_entry_t entry_o,
  output logic                  push_valid_o,
  input  logic                  push_ready_i
);
  import lavm_pkg::*;

  lavm_diff_t dx, dy, dz;

  assign dx = lavm_diff_t'(item_i.eye_x) - lavm_diff_t'(item_i.target_x);
  assign dy = lavm_diff_t'(item_i.eye_y) - lavm_diff_t'(item_i.target_y);
  assign dz = lavm_diff_t'(item_i.eye_z) - lavm_diff_t'(item_i.target_z);

  assign entry_o.eye[0]  = item_i.eye_x;
  assign entry_o.eye[1]  = item_i.eye_y;
  assign entry_o.eye[2]  = item_i.eye_z;
  assign entry_o.diff[0] = dx;
  assign entry_o.diff[1] = dy;
  assign entry_o.diff[2] = dz;
  // no view direction at all
  assign entry_o.same    = (dx == '0) && (dy == '0) && (dz == '0);

  assign push_valid_o = item_i.valid;
  assign item_i.ready = push_ready_i;

endmodule
`default_nettype wire

@@ rtl/lavm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_queue: short queue between front and back end
// Circular buffer of classified updates with valid/ready on both sides.
// ----------------------------------------------------------------------------
module lavm_queue #(
  parameter int unsigned DEPTH = lavm_pkg::QueueDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lavm_pkg::lavm_entry_t push_data_i,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  output lavm_pkg::lavm_entry_t pop_data_o,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i
);
  import lavm_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  lavm_entry_t     mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lavm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_back: basis and matrix sequencer of the look-at view matrix unit
// Shared multiplier, bit-serial square root and divider, row output register.
// ----------------------------------------------------------------------------
module lavm_back #(
  parameter int unsigned FRAC_BITS = lavm_pkg::FracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lavm_pkg::lavm_data_t  up_x_i,
  input  lavm_pkg::lavm_data_t  up_y_i,
  input  lavm_pkg::lavm_data_t  up_z_i,
  input  lavm_pkg::lavm_entry_t entry_i,
  input  logic                  entry_valid_i,
  output logic                  entry_ready_o,
  lavm_row_if.source            row_o
);
  import lavm_pkg::*;

  localparam int unsigned AxW  = FRAC_BITS + 2;
  localparam int unsigned MulW = DataW + 1;
  localparam int unsigned PrW  = 2 * MulW;
  localparam int unsigned QW   = FRAC_BITS + 1;
  localparam int unsigned CW   = $clog2(QW + 1);
  localparam int unsigned MagW = 63;
  localparam int unsigned NrmW = 30;
  localparam int unsigned LenW = NrmW + 1;
  localparam int unsigned NumW = NrmW + QW;
  localparam logic [63:0]        RoundHalf = 64'(1) << (FRAC_BITS - 1);
  localparam logic [63:0]        RootTop   = 64'(1) << 62;
  localparam logic signed [63:0] SatHi     = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SatLo     = -64'sh0000_0000_8000_0000;
  localparam lavm_data_t         OneFix    = DataW'(64'(1) << FRAC_BITS);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_SHIFT = 9'b0_0000_0010,
    S_PROD  = 9'b0_0000_0100,
    S_DRAIN = 9'b0_0000_1000,
    S_POST  = 9'b0_0001_0000,
    S_SQRT  = 9'b0_0010_0000,
    S_DIVLD = 9'b0_0100_0000,
    S_DIV   = 9'b0_1000_0000,
    S_EMIT  = 9'b1_0000_0000
  } lavm_state_e;

  typedef enum logic [1:0] {
    P_SQ  = 2'd0,
    P_CRC = 2'd1,
    P_CRY = 2'd2,
    P_DOT = 2'd3
  } lavm_prog_e;

  lavm_state_e             state_q, state_d;
  lavm_prog_e              prog_q, prog_d;
  logic                    nsel_q, nsel_d;
  logic                    ok_q, ok_d;
  lavm_data_t              eye_q [3], eye_d [3];
  logic [MagW-1:0]         a_q [3], a_d [3];
  logic                    neg_q [3], neg_d [3];
  logic signed [AxW-1:0]   z_q [3], z_d [3];
  logic signed [AxW-1:0]   x_q [3], x_d [3];
  logic signed [AxW-1:0]   y_q [3], y_d [3];
  lavm_data_t              t_q [3], t_d [3];
  logic [1:0]              r_q, r_d, j_q, j_d, ci_q, ci_d;
  logic signed [MulW-1:0]  opa, opb;
  logic                    osub;
  logic signed [PrW-1:0]   prod_q, prod_d;
  logic                    pv_q, pv_d, psub_q, psub_d;
  logic [1:0]              pdst_q, pdst_d;
  logic signed [63:0]      acc_q [3], acc_d [3];
  logic                    acc_clr;
  logic [63:0]             sx_q, sx_d, sr_q, sr_d, sb_q, sb_d;
  logic [LenW-1:0]         len_q, len_d;
  logic [LenW-1:0]         rem_q, rem_d;
  logic [QW-1:0]           lo_q, lo_d, q_q, q_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              orow_q, orow_d;
  lavm_data_t              oc0_q, oc0_d, oc1_q, oc1_d, oc2_q, oc2_d, oc3_q, oc3_d;
  logic                    odeg_q, odeg_d, olast_q, olast_d;

  logic [MagW-1:0]         orv;
  logic [63:0]             sq_trial, sr_nx;
  logic                    sq_ge;
  logic [LenW:0]           dv_trial;
  logic                    dv_ge;
  logic [QW-1:0]           q_nx;
  logic signed [AxW-1:0]   qs, qv;
  logic [NumW-1:0]         num;
  logic [1:0]              jlast, rlast;
  logic                    prod_last;
  logic                    emit_go;

  function automatic logic [1:0] nxt1(input logic [1:0] i);
    case (i)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] nxt2(input logic [1:0] i);
    case (i)
      2'd0:    return 2'd2;
      2'd1:    return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // round half away from zero down to FRAC_BITS fraction bits
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
    logic [63:0] r;
    r = (mag64(v) + RoundHalf) >> FRAC_BITS;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic lavm_data_t sat32(input logic signed [63:0] v);
    if (v > SatHi) begin
      return SatHi[DataW-1:0];
    end else if (v < SatLo) begin
      return SatLo[DataW-1:0];
    end
    return v[DataW-1:0];
  endfunction

  // ---- datapath helpers
  assign orv      = a_q[0] | a_q[1] | a_q[2];
  assign sq_trial = sr_q + sb_q;
  assign sq_ge    = (sx_q >= sq_trial);
  assign sr_nx    = sq_ge ? ((sr_q >> 1) + sb_q) : (sr_q >> 1);
  assign dv_trial = {rem_q, lo_q[QW-1]};
  assign dv_ge    = (dv_trial >= {1'b0, len_q});
  assign q_nx     = {q_q[QW-2:0], dv_ge};
  assign qs       = $signed({1'b0, q_nx});
  assign qv       = neg_q[ci_q] ? -qs : qs;
  assign num      = (NumW'(a_q[ci_q][NrmW-1:0]) << FRAC_BITS) + NumW'(len_q >> 1);
  assign jlast    = ((prog_q == P_SQ) || (prog_q == P_DOT)) ? 2'd2 : 2'd1;
  assign rlast    = (prog_q == P_SQ) ? 2'd0 : 2'd2;
  assign prod_last = (j_q == jlast) && (r_q == rlast);
  assign emit_go  = !out_valid_q || row_o.ready;

  // multiplier operand selection
  always_comb begin
    opa  = '0;
    opb  = '0;
    osub = 1'b0;
    case (prog_q)
      P_SQ: begin
        opa = MulW'(a_q[j_q][NrmW-1:0]);
        opb = MulW'(a_q[j_q][NrmW-1:0]);
      end
      P_CRC: begin
        osub = j_q[0];
        case (r_q)
          2'd0:    opa = MulW'(j_q[0] ? up_z_i : up_y_i);
          2'd1:    opa = MulW'(j_q[0] ? up_x_i : up_z_i);
          default: opa = MulW'(j_q[0] ? up_y_i : up_x_i);
        endcase
        opb = MulW'(j_q[0] ? z_q[nxt1(r_q)] : z_q[nxt2(r_q)]);
      end
      P_CRY: begin
        osub = j_q[0];
        opa  = MulW'(j_q[0] ? z_q[nxt2(r_q)] : z_q[nxt1(r_q)]);
        opb  = MulW'(j_q[0] ? x_q[nxt1(r_q)] : x_q[nxt2(r_q)]);
      end
      default: begin
        case (r_q)
          2'd0:    opa = MulW'(x_q[j_q]);
          2'd1:    opa = MulW'(y_q[j_q]);
          default: opa = MulW'(z_q[j_q]);
        endcase
        opb = MulW'(eye_q[j_q]);
      end
    endcase
  end

  assign prod_d = opa * opb;
  assign pv_d   = (state_q == S_PROD);
  assign psub_d = osub;
  assign pdst_d = (prog_q == P_SQ) ? 2'd0 : r_q;

  // accumulators
  always_comb begin
    acc_d = acc_q;
    for (int i = 0; i < 3; i++) begin
      if (acc_clr) begin
        acc_d[i] = '0;
      end else if (pv_q && (pdst_q == 2'(i))) begin
        acc_d[i] = psub_q ? acc_q[i] - prod_q[63:0] : acc_q[i] + prod_q[63:0];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    prog_d      = prog_q;
    nsel_d      = nsel_q;
    ok_d        = ok_q;
    eye_d       = eye_q;
    a_d         = a_q;
    neg_d       = neg_q;
    z_d         = z_q;
    x_d         = x_q;
    y_d         = y_q;
    t_d         = t_q;
    r_d         = r_q;
    j_d         = j_q;
    ci_d        = ci_q;
    acc_clr     = 1'b0;
    sx_d        = sx_q;
    sr_d        = sr_q;
    sb_d        = sb_q;
    len_d       = len_q;
    rem_d       = rem_q;
    lo_d        = lo_q;
    q_d         = q_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !row_o.ready;
    orow_d      = orow_q;
    oc0_d       = oc0_q;
    oc1_d       = oc1_q;
    oc2_d       = oc2_q;
    oc3_d       = oc3_q;
    odeg_d      = odeg_q;
    olast_d     = olast_q;
    entry_ready_o = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (entry_valid_i) begin
          for (int i = 0; i < 3; i++) begin
            eye_d[i] = entry_i.eye[i];
            a_d[i]   = MagW'($unsigned(entry_i.diff[i][DiffW-1] ? -$signed(entry_i.diff[i])
                                                               : $signed(entry_i.diff[i])));
            neg_d[i] = entry_i.diff[i][DiffW-1];
          end
          nsel_d = 1'b0;
          r_d    = 2'd0;
          if (entry_i.same) begin
            ok_d = 1'b0;
            for (int i = 0; i < 3; i++) begin
              x_d[i] = '0;
              y_d[i] = '0;
              z_d[i] = '0;
              t_d[i] = '0;
            end
            state_d = S_EMIT;
          end else begin
            ok_d    = 1'b1;
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (orv == '0) begin
          // up parallel to the view direction or up is zero
          ok_d = 1'b0;
          r_d  = 2'd0;
          for (int i = 0; i < 3; i++) begin
            x_d[i] = '0;
            y_d[i] = '0;
            z_d[i] = '0;
            t_d[i] = '0;
          end
          state_d = S_EMIT;
        end else if (orv[MagW-1:NrmW] != '0) begin
          for (int i = 0; i < 3; i++) begin
            a_d[i] = a_q[i] >> 1;
          end
        end else if (!orv[NrmW-1]) begin
          for (int i = 0; i < 3; i++) begin
            a_d[i] = a_q[i] << 1;
          end
        end else begin
          prog_d  = P_SQ;
          r_d     = 2'd0;
          j_d     = 2'd0;
          acc_clr = 1'b1;
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        if (j_q == jlast) begin
          j_d = 2'd0;
          r_d = r_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
        if (prod_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_POST;
      end
      S_POST: begin
        case (prog_q)
          P_SQ: begin
            sx_d    = $unsigned(acc_q[0]);
            sr_d    = '0;
            sb_d    = RootTop;
            state_d = S_SQRT;
          end
          P_CRC: begin
            for (int i = 0; i < 3; i++) begin
              a_d[i]   = MagW'(mag64(acc_q[i]));
              neg_d[i] = acc_q[i][63];
            end
            nsel_d  = 1'b1;
            state_d = S_SHIFT;
          end
          P_CRY: begin
            for (int i = 0; i < 3; i++) begin
              y_d[i] = AxW'(rnd(acc_q[i]));
            end
            prog_d  = P_DOT;
            r_d     = 2'd0;
            j_d     = 2'd0;
            acc_clr = 1'b1;
            state_d = S_PROD;
          end
          default: begin
            for (int i = 0; i < 3; i++) begin
              t_d[i] = sat32(-rnd(acc_q[i]));
            end
            r_d     = 2'd0;
            state_d = S_EMIT;
          end
        endcase
      end
      S_SQRT: begin
        if (sq_ge) begin
          sx_d = sx_q - sq_trial;
        end
        sr_d = sr_nx;
        sb_d = sb_q >> 2;
        if (sb_q[0]) begin
          len_d   = sr_nx[LenW-1:0];
          ci_d    = 2'd0;
          state_d = S_DIVLD;
        end
      end
      S_DIVLD: begin
        rem_d   = LenW'(num[NumW-1:QW]);
        lo_d    = num[QW-1:0];
        q_d     = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = dv_ge ? LenW'(dv_trial - {1'b0, len_q}) : LenW'(dv_trial);
        lo_d  = lo_q << 1;
        q_d   = q_nx;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(QW - 1)) begin
          if (nsel_q) begin
            x_d[ci_q] = qv;
          end else begin
            z_d[ci_q] = qv;
          end
          if (ci_q == 2'd2) begin
            prog_d  = nsel_q ? P_CRY : P_CRC;
            r_d     = 2'd0;
            j_d     = 2'd0;
            acc_clr = 1'b1;
            state_d = S_PROD;
          end else begin
            ci_d    = ci_q + 1'b1;
            state_d = S_DIVLD;
          end
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          orow_d      = r_q;
          odeg_d      = !ok_q;
          olast_d     = (r_q == 2'd3);
          case (r_q)
            2'd0: begin
              oc0_d = DataW'(x_q[0]);
              oc1_d = DataW'(x_q[1]);
              oc2_d = DataW'(x_q[2]);
              oc3_d = t_q[0];
            end
            2'd1: begin
              oc0_d = DataW'(y_q[0]);
              oc1_d = DataW'(y_q[1]);
              oc2_d = DataW'(y_q[2]);
              oc3_d = t_q[1];
            end
            2'd2: begin
              oc0_d = DataW'(z_q[0]);
              oc1_d = DataW'(z_q[1]);
              oc2_d = DataW'(z_q[2]);
              oc3_d = t_q[2];
            end
            default: begin
              oc0_d = '0;
              oc1_d = '0;
              oc2_d = '0;
              oc3_d = OneFix;
            end
          endcase
          r_d = r_q + 1'b1;
          if (r_q == 2'd3) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prog_q      <= P_SQ;
      nsel_q      <= 1'b0;
      ok_q        <= 1'b0;
      r_q         <= '0;
      j_q         <= '0;
      ci_q        <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prog_q      <= prog_d;
      nsel_q      <= nsel_d;
      ok_q        <= ok_d;
      r_q         <= r_d;
      j_q         <= j_d;
      ci_q        <= ci_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eye_q   <= eye_d;
    a_q     <= a_d;
    neg_q   <= neg_d;
    z_q     <= z_d;
    x_q     <= x_d;
    y_q     <= y_d;
    t_q     <= t_d;
    prod_q  <= prod_d;
    psub_q  <= psub_d;
    pdst_q  <= pdst_d;
    acc_q   <= acc_d;
    sx_q    <= sx_d;
    sr_q    <= sr_d;
    sb_q    <= sb_d;
    len_q   <= len_d;
    rem_q   <= rem_d;
    lo_q    <= lo_d;
    q_q     <= q_d;
    orow_q  <= orow_d;
    oc0_q   <= oc0_d;
    oc1_q   <= oc1_d;
    oc2_q   <= oc2_d;
    oc3_q   <= oc3_d;
    odeg_q  <= odeg_d;
    olast_q <= olast_d;
  end

  assign row_o.valid      = out_valid_q;
  assign row_o.row_index  = orow_q;
  assign row_o.col0       = oc0_q;
  assign row_o.col1       = oc1_q;
  assign row_o.col2       = oc2_q;
  assign row_o.col3       = oc3_q;
  assign row_o.degenerate = odeg_q;
  assign row_o.last_row   = olast_q;

endmodule
`default_nettype wire

@@ rtl/lavm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_checker: port-level checks of the look-at view matrix unit
// Row numbering, constant last row, degenerate rows and output hold.
// ----------------------------------------------------------------------------
module lavm_checker #(
  parameter int unsigned FRAC_BITS = lavm_pkg::FracBitsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        row_valid,
  input logic        row_ready,
  input logic [1:0]  row_index,
  input logic [31:0] col0,
  input logic [31:0] col1,
  input logic [31:0] col2,
  input logic [31:0] col3,
  input logic        degenerate,
  input logic        last_row
);
  import lavm_pkg::*;

  localparam logic [DataW-1:0] OneFix = DataW'(64'(1) << FRAC_BITS);

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_valid |-> (last_row == (row_index == 2'd3)))
    else $error("last_row does not match row 3");

  a_const_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid && (row_index == 2'd3)) |->
      (col0 == '0) && (col1 == '0) && (col2 == '0) && (col3 == OneFix))
    else $error("row 3 is not 0,0,0,1");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid && degenerate && (row_index != 2'd3)) |->
      (col0 == '0) && (col1 == '0) && (col2 == '0) && (col3 == '0))
    else $error("degenerate basis row is not zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid && !row_ready) |=>
      (row_valid && $stable(row_index) && $stable(col3) && $stable(degenerate)))
    else $error("stalled row changed");

endmodule

bind look_at_view_matrix_unit lavm_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_lavm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .row_valid  (row_o.valid),
  .row_ready  (row_o.ready),
  .row_index  (row_o.row_index),
  .col0       (row_o.col0),
  .col1       (row_o.col1),
  .col2       (row_o.col2),
  .col3       (row_o.col3),
  .degenerate (row_o.degenerate),
  .last_row   (row_o.last_row)
);
`default_nettype wire

@@ test/look_at_view_matrix_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit_tb: self-checking bench for the look-at unit
// Drives camera updates with random gaps, predicts the four view matrix rows
// of each update in fixed point and checks every row transfer in order.
// ----------------------------------------------------------------------------

class lavm_row_board;
  typedef struct {
    logic [1:0]  idx;
    logic [31:0] c0, c1, c2, c3;
    logic        degen, last;
  } row_t;

  row_t        rows_q[$];
  int          errors;
  logic [31:0] up[3];

  function new();
    errors = 0;
    up[0] = 32'h0;
    up[1] = 32'h0001_0000;
    up[2] = 32'h0;
  endfunction

  function void set_up(int idx, logic [31:0] v);
    if (idx < 3) up[idx] = v;
  endfunction

  static function longint unsigned magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  static function longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // block-float alignment to 30 bits, then rounded division by the length
  static function bit unit_vec(longint v[3], output longint o[3]);
    longint unsigned a[3], m, s, len, q;
    int bl;
    m = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = magn(v[i]);
      if (a[i] > m) m = a[i];
    end
    for (int i = 0; i < 3; i++) o[i] = 0;
    if (m == 0) return 0;
    bl = 0;
    while (m != 0) begin
      bl++;
      m >>= 1;
    end
    for (int i = 0; i < 3; i++) begin
      if (bl < 30) a[i] <<= (30 - bl);
      else a[i] >>= (bl - 30);
      s += a[i] * a[i];
    end
    len = root64(s);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 16) + len / 2) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  static function longint rnd16(longint v);
    longint unsigned m;
    m = (magn(v) + 64'd32768) >> 16;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function void note_camera(logic [31:0] eye_w[3], logic [31:0] tgt_w[3]);
    longint eye[3], d[3], c[3], u[3], x[3], y[3], z[3], ax[3], s, t;
    bit ok;
    row_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(eye_w[i]));
      d[i]   = eye[i] - longint'($signed(tgt_w[i]));
      u[i]   = longint'($signed(up[i]));
    end
    ok = unit_vec(d, z);
    if (ok) begin
      c[0] = u[1] * z[2] - u[2] * z[1];
      c[1] = u[2] * z[0] - u[0] * z[2];
      c[2] = u[0] * z[1] - u[1] * z[0];
      ok = unit_vec(c, x);
    end
    if (ok) begin
      y[0] = rnd16(z[1] * x[2] - z[2] * x[1]);
      y[1] = rnd16(z[2] * x[0] - z[0] * x[2]);
      y[2] = rnd16(z[0] * x[1] - z[1] * x[0]);
    end else begin
      for (int i = 0; i < 3; i++) begin
        x[i] = 0;
        y[i] = 0;
        z[i] = 0;
      end
    end
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: ax = x;
        1: ax = y;
        2: ax = z;
        default: ax = '{0, 0, 0};
      endcase
      s = ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2];
      t = -rnd16(s);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      r.idx   = k[1:0];
      r.c0    = ax[0][31:0];
      r.c1    = ax[1][31:0];
      r.c2    = ax[2][31:0];
      r.c3    = (k == 3) ? 32'h0001_0000 : t[31:0];
      r.degen = !ok;
      r.last  = (k == 3);
      rows_q.push_back(r);
    end
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] exp);
    $display("row mismatch on %s: got %h expected %h", what, got, exp);
    errors++;
  endfunction

  function void check_row(row_t g);
    row_t e;
    if (rows_q.size() == 0) begin
      report("unexpected row transfer, row_index", 32'(g.idx), 32'h0);
      return;
    end
    e = rows_q.pop_front();
    if (g.idx !== e.idx) report("row_index", g.idx, e.idx);
    if (g.c0 !== e.c0) report("col0", g.c0, e.c0);
    if (g.c1 !== e.c1) report("col1", g.c1, e.c1);
    if (g.c2 !== e.c2) report("col2", g.c2, e.c2);
    if (g.c3 !== e.c3) report("col3", g.c3, e.c3);
    if (g.degen !== e.degen) report("degenerate", g.degen, e.degen);
    if (g.last !== e.last) report("last_row", g.last, e.last);
  endfunction
endclass

module look_at_view_matrix_unit_tb;
  import lavm_pkg::*;

  localparam int LIMIT = 1_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [DataW-1:0]    cfg_wdata_i = '0;
  int                  cycles = 0;
  int                  hold_off = 0;    // long receiver stall, in cycles
  bit                  sink_busy = 0;   // random sink gaps enabled
  lavm_row_board       board;

  lavm_item_if item_ch ();
  lavm_row_if  row_ch ();

  look_at_view_matrix_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_ch.sink),
    .row_o       (row_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.eye_x = '0;
    item_ch.eye_y = '0;
    item_ch.eye_z = '0;
    item_ch.target_x = '0;
    item_ch.target_y = '0;
    item_ch.target_z = '0;
    row_ch.ready = 1'b0;
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // gap length: mostly short, a few long
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 5) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side: ready with random gaps and an optional long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      row_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      row_ch.ready <= 1'b0;
    end else begin
      row_ch.ready <= sink_busy ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // check every row transfer
  always @(posedge clk_i) begin
    if (rst_ni && row_ch.valid && row_ch.ready)
      board.check_row('{row_ch.row_index, row_ch.col0, row_ch.col1, row_ch.col2,
                        row_ch.col3, row_ch.degenerate, row_ch.last_row});
  end

  // offer one camera update and wait for its transfer
  task automatic send_camera(logic [31:0] ex, ey, ez, tx, ty, tz);
    item_ch.valid    <= 1'b1;
    item_ch.eye_x    <= ex;
    item_ch.eye_y    <= ey;
    item_ch.eye_z    <= ez;
    item_ch.target_x <= tx;
    item_ch.target_y <= ty;
    item_ch.target_z <= tz;
    do @(posedge clk_i); while (!item_ch.ready);
    board.note_camera('{ex, ey, ez}, '{tx, ty, tz});
  endtask

  task automatic send_gap(int n);
    if (n > 0) begin
      item_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // wait for every expected row, then the back end's worst-case latency
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (board.rows_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_up(lavm_cfg_e idx, logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_up(int'(idx), v);
  endtask

  // random coordinate: mostly small Q16.16 numbers, some full-range words
  function automatic logic [31:0] coord();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      default: return 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
    endcase
  endfunction

  task automatic random_cameras(int n);
    logic [31:0] e[3], t[3];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        e[i] = coord();
        t[i] = coord();
      end
      // occasional edge cases: eye equals target (degenerate), or view along y (along up for the default up)
      case ($urandom_range(0, 11))
        0: t = e;
        1: begin
          t = e;
          t[1] = e[1] - 32'($urandom_range(1, 1 << 20));
        end
        default: ;
      endcase
      send_camera(e[0], e[1], e[2], t[0], t[1], t[2]);
      send_gap(gap_len());
    end
  endtask

  initial begin
    logic [31:0] one;
    one = 32'h0001_0000;
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default up
    send_camera(0, 0, 5 * one, 0, 0, 0);
    send_camera(one, 2 * one, 3 * one, one, 2 * one, 3 * one);          // eye equals target
    send_camera(0, 7 * one, 0, 0, -one, 0);                             // view along up
    send_camera(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0001);           // huge difference
    send_camera(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h0);                   // translation saturates
    send_camera(1, 0, 0, 0, 0, 1);                                      // tiny difference
    send_camera(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa,
                32'h0, 32'haaaa_aaaa, 32'h5555_5555);
    send_camera(3 * one, 0, 0, 0, 0, 0);
    drain();

    // zero up vector: everything degenerate
    write_up(CFG_UP_X, 0);
    write_up(CFG_UP_Y, 0);
    write_up(CFG_UP_Z, 0);
    send_camera(0, 0, one, 0, 0, 0);
    send_camera(one, one, one, 0, 0, 0);
    drain();

    // extreme up vectors
    write_up(CFG_UP_X, 32'h7fff_ffff);
    write_up(CFG_UP_Y, 32'h8000_0000);
    write_up(CFG_UP_Z, 32'hffff_ffff);
    send_camera(0, 0, 0, one, 0, 0);
    send_camera(one, -one, 0, 0, 0, 0);
    send_camera(32'h7fff_ffff, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h1);
    drain();

    // default up again; long receiver hold-off while the sender keeps offering
    write_up(CFG_UP_X, 0);
    write_up(CFG_UP_Y, one);
    write_up(CFG_UP_Z, 0);
    hold_off = 3000;
    random_cameras(8);
    drain();
    sink_busy = 1;
    random_cameras(40);
    drain();

    // random up vectors
    for (int p = 0; p < 2; p++) begin
      write_up(CFG_UP_X, coord());
      write_up(CFG_UP_Y, coord());
      write_up(CFG_UP_Z, coord());
      sink_busy = p;
      random_cameras(40);
      drain();
    end

    if (board.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
